[rtl/bla_pkg.sv]
// Shared constants, lookup tables and control types of the band loudness accumulator.
`default_nettype none
package bla_pkg;

  localparam int MAX_BANDS   = 128;
  localparam int LUT_BITS    = 6;
  localparam int LUT_SIZE    = 1 << LUT_BITS;
  localparam int FRAC_SHIFT  = 16 - LUT_BITS;
  localparam int ADDR_W      = $clog2(MAX_BANDS);
  localparam int NORM_STEPS  = 6;

  localparam logic [13:0] POW_COEF    = 14'd15073;   // 0.23 in Q0.16
  localparam logic [24:0] INV_MAX     = 25'd16777216;
  localparam logic [20:0] SCALE_RESET = 21'd14431;
  localparam logic [47:0] SUM_MAX     = 48'hFFFF_FFFF_FFFF;

  typedef logic [17:0] lut_t [LUT_SIZE+1];

  typedef struct packed {
    logic       load;
    logic       rmul;
    logic       rsum;
    logic       xmul;
    logic       xsum;
    logic       norm;
    logic [2:0] norm_step;
    logic       log_step;
    logic       pow;
    logic       exp_step;
    logic       mull;
    logic       acc;
    logic       tmul;
    logic       tout;
  } bla_cmd_t;

  typedef struct packed {
    logic item_exc;
    logic item_last;
    logic out_free;
  } bla_stat_t;

  function automatic logic [63:0] floor_sqrt(input logic [63:0] val);
    logic [63:0] v;
    logic [63:0] res;
    logic [63:0] bitv;
    int n;
    v    = val;
    res  = 64'd0;
    bitv = 64'd1 << 62;
    for (n = 0; n < 32; n++) begin
      if (v >= res + bitv) begin
        v   = v - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  // log2(1 + i/LUT_SIZE) in Q0.16 by bit-serial squaring
  function automatic lut_t make_log_tab();
    lut_t tab;
    logic [63:0] m;
    logic [31:0] frac;
    int i;
    int b;
    for (i = 0; i < LUT_SIZE; i++) begin
      m    = (64'd1 << 30) + (64'(i) << (30 - LUT_BITS));
      frac = 32'd0;
      for (b = 0; b < 20; b++) begin
        m    = (m * m) >> 30;
        frac = frac << 1;
        if (m >= (64'd2 << 30)) begin
          m    = m >> 1;
          frac = frac | 32'd1;
        end
      end
      tab[i] = 18'((frac + 32'd8) >> 4);
    end
    tab[LUT_SIZE] = 18'd65536;
    return tab;
  endfunction

  // 2^(j/LUT_SIZE) in Q1.16 as a product of repeated square roots of two
  function automatic lut_t make_exp_tab();
    lut_t tab;
    logic [63:0] roots [LUT_BITS+1];
    logic [63:0] v;
    int i;
    int k;
    roots[0] = 64'd2 << 30;
    for (k = 1; k <= LUT_BITS; k++) roots[k] = floor_sqrt(roots[k-1] << 30);
    for (i = 0; i < LUT_SIZE; i++) begin
      v = 64'd1 << 30;
      for (k = 1; k <= LUT_BITS; k++) begin
        if (((i >> (LUT_BITS - k)) & 1) != 0) v = (v * roots[k] + (64'd1 << 29)) >> 30;
      end
      tab[i] = 18'((v + 64'd8192) >> 14);
    end
    tab[LUT_SIZE] = 18'd131072;
    return tab;
  endfunction

  localparam lut_t LOG_TAB = make_log_tab();
  localparam lut_t EXP_TAB = make_exp_tab();

endpackage
`default_nettype wire

[rtl/bla_ctrl.sv]
// Sequencer that steps one band through the datapath and closes frames.
`default_nettype none
module bla_ctrl
  import bla_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      in_valid,
  output logic           in_stall,
  input  wire bla_stat_t stat,
  output bla_cmd_t       cmd
);

  typedef enum logic [12:0] {
    S_IDLE = 13'b0000000000001,
    S_RMUL = 13'b0000000000010,
    S_RSUM = 13'b0000000000100,
    S_XMUL = 13'b0000000001000,
    S_XSUM = 13'b0000000010000,
    S_NORM = 13'b0000000100000,
    S_LOG  = 13'b0000001000000,
    S_POW  = 13'b0000010000000,
    S_EXP  = 13'b0000100000000,
    S_MULL = 13'b0001000000000,
    S_ACC  = 13'b0010000000000,
    S_TMUL = 13'b0100000000000,
    S_TOUT = 13'b1000000000000
  } state_t;

  state_t     state, state_next;
  logic [2:0] step, step_next;

  always_comb begin
    state_next = state;
    step_next  = step;
    case (state)
      S_IDLE: if (in_valid && stat.item_exc) state_next = S_RMUL;
      S_RMUL: state_next = S_RSUM;
      S_RSUM: state_next = S_XMUL;
      S_XMUL: state_next = S_XSUM;
      S_XSUM: begin
        state_next = S_NORM;
        step_next  = 3'd0;
      end
      S_NORM: begin
        if (step == 3'(NORM_STEPS - 1)) state_next = S_LOG;
        else step_next = step + 3'd1;
      end
      S_LOG:  state_next = S_POW;
      S_POW:  state_next = S_EXP;
      S_EXP:  state_next = S_MULL;
      S_MULL: state_next = S_ACC;
      S_ACC:  state_next = stat.item_last ? S_TMUL : S_IDLE;
      S_TMUL: state_next = S_TOUT;
      S_TOUT: if (stat.out_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      step  <= 3'd0;
    end else begin
      state <= state_next;
      step  <= step_next;
    end
  end

  assign in_stall = (state != S_IDLE);

  always_comb begin
    cmd           = '0;
    cmd.load      = (state == S_IDLE) && in_valid;
    cmd.rmul      = (state == S_RMUL);
    cmd.rsum      = (state == S_RSUM);
    cmd.xmul      = (state == S_XMUL);
    cmd.xsum      = (state == S_XSUM);
    cmd.norm      = (state == S_NORM);
    cmd.norm_step = step;
    cmd.log_step  = (state == S_LOG);
    cmd.pow       = (state == S_POW);
    cmd.exp_step  = (state == S_EXP);
    cmd.mull      = (state == S_MULL);
    cmd.acc       = (state == S_ACC);
    cmd.tmul      = (state == S_TMUL);
    cmd.tout      = (state == S_TOUT) && stat.out_free;
  end

  a_exc_starts: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE && in_valid && stat.item_exc) |=> (state == S_RMUL))
    else $error("excitation transaction did not start the band sequence");

  a_norm_ends: assert property (@(posedge clk) disable iff (rst)
    (state == S_NORM && step == 3'(NORM_STEPS - 1)) |=> (state == S_LOG))
    else $error("normalize did not finish after its last step");

  a_tout_holds: assert property (@(posedge clk) disable iff (rst)
    (state == S_TOUT && !stat.out_free) |=> (state == S_TOUT))
    else $error("total left before the output register was free");

endmodule
`default_nettype wire

[rtl/bla_dp.sv]
// Datapath: coefficient memory, band arithmetic, running sum and output register.
`default_nettype none
module bla_dp
  import bla_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire bla_cmd_t    cmd,
  output bla_stat_t        stat,
  input  wire logic        action,
  input  wire logic [6:0]  band,
  input  wire logic [47:0] excitation,
  input  wire logic [15:0] threshold_coef,
  input  wire logic [24:0] inv_exc_threshold,
  input  wire logic [23:0] loud_coef,
  input  wire logic        last,
  input  wire logic        cfg_write,
  input  wire logic [20:0] cfg_data,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [31:0]      total_loudness,
  output logic             overflow
);

  function automatic logic [17:0] lut_interp(input lut_t tab, input logic [15:0] f);
    logic [LUT_BITS-1:0]        idx;
    logic [FRAC_SHIFT-1:0]      t;
    logic [17:0]                lo;
    logic [17:0]                hi;
    logic [17:0]                diff;
    logic [17+FRAC_SHIFT:0]     prod;
    idx  = f[15:FRAC_SHIFT];
    t    = f[FRAC_SHIFT-1:0];
    lo   = tab[{1'b0, idx}];
    hi   = tab[(LUT_BITS+1)'({1'b0, idx}) + (LUT_BITS+1)'(1)];
    diff = (hi >= lo) ? hi - lo : 18'd0;
    prod = (18+FRAC_SHIFT)'(diff) * (18+FRAC_SHIFT)'(t);
    return lo + 18'(prod >> FRAC_SHIFT);
  endfunction

  logic [64:0]       mem [MAX_BANDS];
  logic [64:0]       coef;
  logic [ADDR_W-1:0] addr;
  logic              band_ok;
  logic [24:0]       inv_clamp;

  logic [47:0] exc_q;
  logic        last_q;
  logic        band_ok_q;
  logic [20:0] frame_scale;

  logic [48:0] prod_hi, prod_lo, r_q;
  logic [40:0] sr_hi;
  logic [39:0] sr_lo;
  logic [64:0] sr_full;
  logic [49:0] x_full;
  logic [48:0] m_q;
  logic        zero_q;
  logic [5:0]  e_q;
  logic [5:0]  k;
  logic [22:0] lg_q;
  logic [18:0] y_q;
  logic [36:0] y_prod;
  logic [24:0] pw_q;
  logic [23:0] d;
  logic [47:0] ld_q;
  logic [48:0] sum_next;
  logic [47:0] loud_sum;
  logic        sum_sat;
  logic [52:0] th_q;
  logic [36:0] tl_q;
  logic [53:0] total;

  wire [15:0] s_c   = coef[64:49];
  wire [24:0] inv_c = coef[48:24];
  wire [23:0] l_c   = coef[23:0];

  assign addr      = ADDR_W'(band);
  assign band_ok   = (32'(band) < 32'(MAX_BANDS));
  assign inv_clamp = (inv_exc_threshold > INV_MAX) ? INV_MAX : inv_exc_threshold;

  // coefficient store: write on load, registered read on excitation
  always_ff @(posedge clk) begin
    if (cmd.load && !action && band_ok)
      mem[addr] <= {threshold_coef, inv_clamp, loud_coef};
    if (cmd.load && action)
      coef <= mem[addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.load && action) begin
      exc_q     <= excitation;
      last_q    <= last;
      band_ok_q <= band_ok;
    end
  end

  assign sr_full = {sr_hi, 24'd0} + 65'(sr_lo);
  assign x_full  = 50'd65536 - 50'(s_c) + 50'(sr_full >> 16);
  assign k       = 6'd32 >> cmd.norm_step;
  assign y_prod  = 37'(lg_q) * 37'(POW_COEF) + 37'd32768;
  assign d       = (pw_q > 25'd65536) ? 24'(pw_q - 25'd65536) : 24'd0;

  // band arithmetic, one stage per command
  always_ff @(posedge clk) begin
    if (cmd.rmul) begin
      prod_hi <= 49'(exc_q[47:24]) * 49'(inv_c);
      prod_lo <= 49'(exc_q[23:0]) * 49'(inv_c);
    end
    if (cmd.rsum) r_q <= prod_hi + 49'(prod_lo[48:24]);
    if (cmd.xmul) begin
      sr_hi <= 41'(s_c) * 41'(r_q[48:24]);
      sr_lo <= 40'(s_c) * 40'(r_q[23:0]);
    end
    if (cmd.xsum) begin
      m_q    <= 49'(x_full);
      zero_q <= (x_full <= 50'd65536);
      e_q    <= 6'd0;
    end
    if (cmd.norm && ((m_q >> (7'd16 + 7'(k))) != 49'd0)) begin
      m_q <= m_q >> k;
      e_q <= e_q + k;
    end
    if (cmd.log_step)
      lg_q <= (23'(e_q) << 16) + 23'(lut_interp(LOG_TAB, m_q[15:0]));
    if (cmd.pow) y_q <= y_prod[34:16];
    // exponent is at most seven here since the log stays below 33
    if (cmd.exp_step)
      pw_q <= 25'(lut_interp(EXP_TAB, y_q[15:0])) << y_q[18:16];
    if (cmd.mull)
      ld_q <= (zero_q || !band_ok_q) ? 48'd0 : 48'(l_c) * 48'(d);
    if (cmd.tmul) begin
      th_q <= 53'(loud_sum[47:16]) * 53'(frame_scale);
      tl_q <= 37'(loud_sum[15:0]) * 37'(frame_scale);
    end
  end

  assign sum_next = 49'(loud_sum) + 49'(ld_q[47:16]);
  assign total    = 54'(th_q) + 54'(tl_q[36:16]);

  always_ff @(posedge clk) begin
    if (rst) begin
      loud_sum    <= 48'd0;
      sum_sat     <= 1'b0;
      frame_scale <= SCALE_RESET;
      out_valid   <= 1'b0;
    end else begin
      if (cfg_write) frame_scale <= cfg_data;
      if (cmd.acc) begin
        if (sum_next > 49'(SUM_MAX)) begin
          loud_sum <= SUM_MAX;
          sum_sat  <= 1'b1;
        end else begin
          loud_sum <= sum_next[47:0];
        end
      end
      if (cmd.tout) begin
        loud_sum  <= 48'd0;
        sum_sat   <= 1'b0;
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.tout) begin
      if (total > 54'hFFFF_FFFF) begin
        total_loudness <= 32'hFFFF_FFFF;
        overflow       <= 1'b1;
      end else begin
        total_loudness <= total[31:0];
        overflow       <= sum_sat;
      end
    end
  end

  assign stat.item_exc  = action;
  assign stat.item_last = last_q;
  assign stat.out_free  = !out_valid || !out_stall;

  a_frame_clears: assert property (@(posedge clk) disable iff (rst)
    cmd.tout |=> (out_valid && loud_sum == 48'd0 && !sum_sat))
    else $error("frame close did not clear the sum or raise out_valid");

  a_sum_grows: assert property (@(posedge clk) disable iff (rst)
    !cmd.tout |=> (loud_sum >= $past(loud_sum)))
    else $error("running sum decreased inside a frame");

endmodule
`default_nettype wire

[rtl/band_loudness_accumulator_top.sv]
// Top level of the band loudness accumulator: sequencer plus datapath.
//
// Input channel (in_valid / in_stall): a transaction with action 0 loads the
// threshold index, reciprocal threshold and loudness factor of one band into
// the coefficient memory while the sequencer stays idle. A transaction with
// action 1 supplies the excitation of a band and holds in_stall while it
// runs through the single shared arithmetic path (two product stages for the
// ratio, two for x, six normalize steps, then log, power, exp, factor and
// accumulate). An excitation transaction with last set also closes the frame:
// the total is scaled, saturated and placed in the output register once that
// register is free, and the running sum clears.
// Output channel (out_valid / out_stall): one transaction per frame with
// total_loudness and overflow. The output register holds the result while
// the receiver stalls; the block keeps taking bands meanwhile and only
// waits when a second total is ready before the first is taken.
// cfg_write loads frame_scale; write it only while the block is idle.
// Reset (rst, synchronous) clears the sum, the overflow state, the output
// valid and restores frame_scale; coefficients must be loaded again.
`default_nettype none
module band_loudness_accumulator_top
  import bla_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        action,
  input  wire logic [6:0]  band,
  input  wire logic [47:0] excitation,
  input  wire logic [15:0] threshold_coef,
  input  wire logic [24:0] inv_exc_threshold,
  input  wire logic [23:0] loud_coef,
  input  wire logic        last,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [31:0]      total_loudness,
  output logic             overflow,
  input  wire logic        cfg_write,
  input  wire logic [20:0] cfg_data
);

  bla_cmd_t  cmd;
  bla_stat_t stat;

  // sequencer: owns in_stall and issues one command per cycle, except while it waits in TOUT for the output register
  bla_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  // datapath: coefficient memory, arithmetic stages and output register
  bla_dp u_dp (
    .clk               (clk),
    .rst               (rst),
    .cmd               (cmd),
    .stat              (stat),
    .action            (action),
    .band              (band),
    .excitation        (excitation),
    .threshold_coef    (threshold_coef),
    .inv_exc_threshold (inv_exc_threshold),
    .loud_coef         (loud_coef),
    .last              (last),
    .cfg_write         (cfg_write),
    .cfg_data          (cfg_data),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .total_loudness    (total_loudness),
    .overflow          (overflow)
  );

endmodule
`default_nettype wire
